// File: design/rta_pkg.sv
package rta_pkg;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_OVERLAP  = 3'd3;
	localparam logic [2:0] ST_UNMAPPED = 3'd4;
	localparam logic [2:0] ST_CROSS    = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;

	// One stored window.
	typedef struct packed {
		logic [63:0] base;
		logic [63:0] wend;
		logic [7:0]  owner;
	} entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic        eval;
		logic        ins;
		logic [63:0] addr;
		logic [63:0] aend;
		logic [7:0]  owner;
	} ctrl_t;

	// Per-cell evaluation result, zero where the cell does not match.
	typedef struct packed {
		logic        ovn;
		logic        ovp;
		logic        sel;
		logic        unm;
		logic        crs;
		logic [7:0]  own_n;
		logic [7:0]  own_p;
		logic [7:0]  own_s;
		logic [63:0] off;
	} res_t;

endpackage

// File: design/rta_cell.sv
module rta_cell (
	input  logic           clk,
	input  logic           vld,
	input  logic           left_lt,
	input  logic           right_lt,
	input  logic           right_le,
	input  rta_pkg::entry_t left_entry,
	input  rta_pkg::ctrl_t  ctrl,
	output logic           lt,
	output logic           le,
	output rta_pkg::entry_t entry,
	output rta_pkg::res_t   res
);

	rta_pkg::entry_t ent_q;
	rta_pkg::res_t   res_q;
	rta_pkg::res_t   res_d;
	logic            lt_q;
	logic            pos_q;
	logic            pos_hit;
	logic            first;
	logic            last_below;

	// Compare the stored base against the key and combine with the neighbors.
	always_comb begin
		lt         = vld && (ent_q.base < ctrl.addr);
		le         = vld && (ent_q.base <= ctrl.addr);
		pos_hit    = !lt && left_lt;
		first      = vld && pos_hit;
		last_below = lt && !right_lt;
		res_d      = '0;
		res_d.ovn  = first && (ctrl.aend > ent_q.base);
		res_d.ovp  = last_below && (ctrl.addr < ent_q.wend);
		res_d.sel  = le && !right_le;
		res_d.unm  = res_d.sel && (ctrl.addr >= ent_q.wend);
		res_d.crs  = res_d.sel && (ctrl.aend > ent_q.wend);
		if (res_d.ovn) begin
			res_d.own_n = ent_q.owner;
		end
		if (res_d.ovp) begin
			res_d.own_p = ent_q.owner;
		end
		if (res_d.sel) begin
			res_d.own_s = ent_q.owner;
			res_d.off   = ctrl.addr - ent_q.base;
		end
	end

	// Capture the result, then shift right or load the new window on insert.
	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			res_q <= res_d;
			lt_q  <= lt;
			pos_q <= pos_hit;
		end
		if (ctrl.ins && !lt_q) begin
			if (pos_q) begin
				ent_q.base  <= ctrl.addr;
				ent_q.wend  <= ctrl.aend;
				ent_q.owner <= ctrl.owner;
			end else begin
				ent_q <= left_entry;
			end
		end
	end

	assign entry = ent_q;
	assign res   = res_q;

endmodule

// File: design/region_table_address_decoder.sv
// Channel  | Handshake              | Payload
// request  | req_valid / req_ready  | mode, address, length, owner_id
// response | rsp_valid / rsp_ready  | status, matched_owner, offset, regions_in_use
//
// The end address is formed as a request is accepted and captured with it.
// Each item then passes an evaluate step, in which every cell of the window chain
// compares in parallel, and a merge step, in which the cell results are merged.
// The result is registered and any insert shifts the chain at the end of the merge cycle.
// A new request is taken in the cycle its predecessor's result is registered.
// A stalled response holds the next item in the merge step until taken.
// Reset empties the table; window contents stay undefined until written.
module region_table_address_decoder #(
	parameter int MAX_REGIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        mode,
	input  logic [63:0] address,
	input  logic [63:0] length,
	input  logic [7:0]  owner_id,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [7:0]  matched_owner,
	output logic [63:0] offset,
	output logic [4:0]  regions_in_use
);

	localparam int CW = $clog2(MAX_REGIONS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]  state_q;
	logic [CW-1:0] count_q;
	logic        rsp_valid_q;
	logic        mode_q;
	logic        zero_q;
	logic        ovf_q;
	logic [63:0] addr_q;
	logic [63:0] aend_q;
	logic [7:0]  owner_q;
	logic [64:0] sum;
	logic        accept;
	logic        commit;
	logic        do_ins;

	logic [2:0]  status_q;
	logic [7:0]  owner_out_q;
	logic [63:0] offset_q;
	logic [2:0]  st_d;
	logic [7:0]  own_d;
	logic [63:0] off_d;

	rta_pkg::ctrl_t  ctrl;
	logic [MAX_REGIONS-1:0] lt_w;
	logic [MAX_REGIONS-1:0] le_w;
	logic [MAX_REGIONS-1:0] sel_v;
	rta_pkg::entry_t ent_w [MAX_REGIONS];
	rta_pkg::res_t   res_w [MAX_REGIONS];
	rta_pkg::res_t   merged;

	assign commit    = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == S_IDLE) || commit;
	assign accept    = req_valid && req_ready;
	assign sum       = {1'b0, address} + {1'b0, length};

	// Control state: sequencer, table fill count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end else if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Capture the transaction and its end address.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			addr_q  <= address;
			aend_q  <= sum[63:0];
			ovf_q   <= sum[64];
			zero_q  <= (length == 64'd0);
			owner_q <= owner_id;
		end
		if (commit) begin
			status_q    <= st_d;
			owner_out_q <= own_d;
			offset_q    <= off_d;
		end
	end

	always_comb begin
		ctrl       = '0;
		ctrl.eval  = (state_q == S_EVAL);
		ctrl.ins   = do_ins;
		ctrl.addr  = addr_q;
		ctrl.aend  = aend_q;
		ctrl.owner = owner_q;
	end

	// The chain of window cells, sorted by base from cell 0 upward.
	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		logic           left_lt;
		logic           right_lt;
		logic           right_le;
		rta_pkg::entry_t left_entry;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_lt    = lt_w[i-1];
			assign left_entry = ent_w[i-1];
		end
		if (i == MAX_REGIONS - 1) begin : g_last
			assign right_lt = 1'b0;
			assign right_le = 1'b0;
		end else begin : g_inner
			assign right_lt = lt_w[i+1];
			assign right_le = le_w[i+1];
		end

		rta_cell u_cell (
			.clk        (clk),
			.vld        (CW'(i) < count_q),
			.left_lt    (left_lt),
			.right_lt   (right_lt),
			.right_le   (right_le),
			.left_entry (left_entry),
			.ctrl       (ctrl),
			.lt         (lt_w[i]),
			.le         (le_w[i]),
			.entry      (ent_w[i]),
			.res        (res_w[i])
		);
	end

	// Merge the per-cell results; at most one cell raises each flag.
	always_comb begin
		merged = '0;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			merged   = merged | res_w[i];
			sel_v[i] = res_w[i].sel;
		end
	end

	// Decide status in the order the checks are defined.
	always_comb begin
		st_d   = rta_pkg::ST_OK;
		own_d  = '0;
		off_d  = '0;
		do_ins = 1'b0;
		if (!mode_q) begin
			if (zero_q) begin
				st_d = rta_pkg::ST_ZERO;
			end else if (ovf_q) begin
				st_d = rta_pkg::ST_OVERFLOW;
			end else if (merged.ovn) begin
				st_d  = rta_pkg::ST_OVERLAP;
				own_d = merged.own_n;
			end else if (merged.ovp) begin
				st_d  = rta_pkg::ST_OVERLAP;
				own_d = merged.own_p;
			end else if (count_q >= CW'(MAX_REGIONS)) begin
				st_d = rta_pkg::ST_FULL;
			end else begin
				do_ins = commit;
			end
		end else begin
			if (ovf_q) begin
				st_d = rta_pkg::ST_OVERFLOW;
			end else if (!merged.sel || merged.unm) begin
				st_d = rta_pkg::ST_UNMAPPED;
			end else if (merged.crs) begin
				st_d = rta_pkg::ST_CROSS;
			end else begin
				own_d = merged.own_s;
				off_d = merged.off;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign matched_owner  = owner_out_q;
	assign offset         = offset_q;
	assign regions_in_use = 5'(count_q);

	// The fill count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("window count exceeds table size");

	// An accepted transaction is evaluated in the next cycle.
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EVAL)
		else $error("accepted transaction not evaluated");

	// Evaluation always leads to the merge step.
	a_eval_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> state_q == S_DONE)
		else $error("evaluation not followed by merge");

	// At most one cell holds the window at or below a lookup address.
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> $onehot0(sel_v))
		else $error("several cells selected");

	// An insert grows the table by exactly one window.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not advance window count");

endmodule
